@@ design/tlrs_pkg.sv @@
package tlrs_pkg;

    localparam int LINE_W    = 12;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 2;
    localparam int PIX_W     = 8;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_HEIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MERGE_GAP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THIN_LIMIT = 2'd2;

    localparam logic [CFG_W-1:0] MIN_HEIGHT_RST = 12'd10;
    localparam logic [CFG_W-1:0] MERGE_GAP_RST  = 12'd2;
    localparam logic [CFG_W-1:0] THIN_LIMIT_RST = 12'd20;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = 2;
    localparam int CNT_W      = 3;

    typedef struct packed {
        logic [LINE_W-1:0] line_start;
        logic [LINE_W-1:0] line_end;
        logic              has_line;
        logic              was_merged;
        logic              last_of_image;
    } res_t;

endpackage

@@ design/text_line_row_segmenter_unit.sv @@
// Channel   Handshake                Payload
// input     in_valid / in_stall      pixel, row_end, image_end
// output    out_valid / out_stall    line_start, line_end, has_line, was_merged, last_of_image
// config    cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One pixel word is taken every cycle while in_stall is low; the row state is updated in the same cycle.
// Results are registered into a four-entry result queue and are offered from its head.
// The input stalls only when fewer than two queue entries are free.
// Reset clears the row state, the pending line and the queue, and loads the register defaults.
module text_line_row_segmenter_unit #(
    parameter int MAX_ROWS = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [tlrs_pkg::PIX_W-1:0]      pixel,
    input  logic                            row_end,
    input  logic                            image_end,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [tlrs_pkg::LINE_W-1:0]     line_start,
    output logic [tlrs_pkg::LINE_W-1:0]     line_end,
    output logic                            has_line,
    output logic                            was_merged,
    output logic                            last_of_image,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tlrs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tlrs_pkg::CFG_W-1:0]      cfg_data
);

    localparam int RW = $clog2(MAX_ROWS);
    localparam int CW = (RW > tlrs_pkg::CFG_W) ? RW : tlrs_pkg::CFG_W;
    localparam logic [RW-1:0] ROW_MAX = RW'(MAX_ROWS - 1);

    function automatic logic [tlrs_pkg::LINE_W-1:0] to_line(input logic [RW-1:0] v);
        logic [CW-1:0] w;
        w = CW'(v);
        return w[tlrs_pkg::LINE_W-1:0];
    endfunction

    logic [tlrs_pkg::CFG_W-1:0] min_height_reg;
    logic [tlrs_pkg::CFG_W-1:0] merge_gap_reg;
    logic [tlrs_pkg::CFG_W-1:0] thin_limit_reg;

    logic [RW-1:0] row_index_reg, row_index_next;
    logic          row_has_ink_reg, row_has_ink_next;
    logic          in_run_reg, in_run_next;
    logic [RW-1:0] run_start_reg, run_start_next;
    logic          pending_valid_reg, pending_valid_next;
    logic [RW-1:0] pending_start_reg, pending_start_next;
    logic [RW-1:0] pending_end_reg, pending_end_next;

    tlrs_pkg::res_t fifo_reg [tlrs_pkg::FIFO_DEPTH];
    logic [tlrs_pkg::PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [tlrs_pkg::CNT_W-1:0] count_reg, count_next;

    logic          accept;
    logic          pop;
    logic          ink_row;
    logic          row_done;
    logic          run_close;
    logic [RW-1:0] height;
    logic [RW-1:0] gap;
    logic [RW-1:0] pend_height;
    logic          keep;
    logic          merge;
    logic          emit_line;
    logic          emit_last;
    logic          pend_after_valid;
    logic [RW-1:0] pend_after_start;
    logic [RW-1:0] pend_after_end;
    tlrs_pkg::res_t res_line;
    tlrs_pkg::res_t res_last;
    tlrs_pkg::res_t wr_data0;
    logic [1:0]    push_n;

    assign cfg_ready = 1'b1;

    assign accept   = in_valid && !in_stall;
    assign pop      = out_valid && !out_stall;
    assign in_stall = (count_reg > tlrs_pkg::CNT_W'(tlrs_pkg::FIFO_DEPTH - 2));
    assign out_valid = (count_reg != '0);

    assign line_start    = fifo_reg[rd_ptr_reg].line_start;
    assign line_end      = fifo_reg[rd_ptr_reg].line_end;
    assign has_line      = fifo_reg[rd_ptr_reg].has_line;
    assign was_merged    = fifo_reg[rd_ptr_reg].was_merged;
    assign last_of_image = fifo_reg[rd_ptr_reg].last_of_image;

    assign ink_row     = row_has_ink_reg || (pixel == '0);
    assign row_done    = row_end || image_end;
    assign run_close   = row_done && !ink_row && in_run_reg;
    assign height      = row_index_reg - run_start_reg;
    assign keep        = run_close && (CW'(height) >= CW'(min_height_reg));
    assign gap         = run_start_reg - pending_end_reg;
    assign pend_height = pending_end_reg - pending_start_reg;
    assign merge       = (CW'(gap) <= CW'(merge_gap_reg))
                      && (CW'(pend_height) < CW'(thin_limit_reg));
    assign emit_line   = keep && pending_valid_reg;
    assign emit_last   = image_end;

    always_comb
    begin
        res_line.line_start    = to_line(pending_start_reg);
        res_line.line_end      = merge ? to_line(row_index_reg) : to_line(pending_end_reg);
        res_line.has_line      = 1'b1;
        res_line.was_merged    = merge;
        res_line.last_of_image = 1'b0;

        pend_after_valid = pending_valid_reg;
        pend_after_start = pending_start_reg;
        pend_after_end   = pending_end_reg;
        if (keep)
        begin
            if (pending_valid_reg && merge)
            begin
                pend_after_valid = 1'b0;
            end
            else
            begin
                pend_after_valid = 1'b1;
                pend_after_start = run_start_reg;
                pend_after_end   = row_index_reg;
            end
        end

        res_last.has_line      = pend_after_valid;
        res_last.line_start    = pend_after_valid ? to_line(pend_after_start) : '0;
        res_last.line_end      = pend_after_valid ? to_line(pend_after_end) : '0;
        res_last.was_merged    = 1'b0;
        res_last.last_of_image = 1'b1;

        wr_data0 = emit_line ? res_line : res_last;
        push_n   = accept ? (2'(emit_line) + 2'(emit_last)) : 2'd0;
    end

    always_comb
    begin
        row_index_next     = row_index_reg;
        row_has_ink_next   = row_has_ink_reg;
        in_run_next        = in_run_reg;
        run_start_next     = run_start_reg;
        pending_valid_next = pending_valid_reg;
        pending_start_next = pending_start_reg;
        pending_end_next   = pending_end_reg;
        if (accept)
        begin
            if (!row_done)
            begin
                row_has_ink_next = ink_row;
            end
            else
            begin
                row_has_ink_next   = 1'b0;
                pending_valid_next = pend_after_valid;
                pending_start_next = pend_after_start;
                pending_end_next   = pend_after_end;
                if (ink_row && !in_run_reg)
                begin
                    in_run_next    = 1'b1;
                    run_start_next = row_index_reg;
                end
                else if (run_close)
                begin
                    in_run_next = 1'b0;
                end
                if (row_index_reg < ROW_MAX)
                begin
                    row_index_next = row_index_reg + 1'b1;
                end
                if (image_end)
                begin
                    pending_valid_next = 1'b0;
                    in_run_next        = 1'b0;
                    row_index_next     = '0;
                end
            end
        end
        count_next = count_reg + tlrs_pkg::CNT_W'(push_n) - tlrs_pkg::CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_height_reg    <= tlrs_pkg::MIN_HEIGHT_RST;
            merge_gap_reg     <= tlrs_pkg::MERGE_GAP_RST;
            thin_limit_reg    <= tlrs_pkg::THIN_LIMIT_RST;
            row_index_reg     <= '0;
            row_has_ink_reg   <= 1'b0;
            in_run_reg        <= 1'b0;
            run_start_reg     <= '0;
            pending_valid_reg <= 1'b0;
            pending_start_reg <= '0;
            pending_end_reg   <= '0;
            wr_ptr_reg        <= '0;
            rd_ptr_reg        <= '0;
            count_reg         <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    tlrs_pkg::REG_MIN_HEIGHT: min_height_reg <= cfg_data;
                    tlrs_pkg::REG_MERGE_GAP:  merge_gap_reg  <= cfg_data;
                    tlrs_pkg::REG_THIN_LIMIT: thin_limit_reg <= cfg_data;
                    default: ;
                endcase
            end
            row_index_reg     <= row_index_next;
            row_has_ink_reg   <= row_has_ink_next;
            in_run_reg        <= in_run_next;
            run_start_reg     <= run_start_next;
            pending_valid_reg <= pending_valid_next;
            pending_start_reg <= pending_start_next;
            pending_end_reg   <= pending_end_next;
            wr_ptr_reg        <= wr_ptr_reg + tlrs_pkg::PTR_W'(push_n);
            rd_ptr_reg        <= rd_ptr_reg + tlrs_pkg::PTR_W'(pop);
            count_reg         <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            fifo_reg[wr_ptr_reg] <= wr_data0;
        end
        if (push_n == 2'd2)
        begin
            fifo_reg[wr_ptr_reg + 1'b1] <= res_last;
        end
    end

endmodule

@@ design/tlrs_checker.sv @@
module tlrs_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic [tlrs_pkg::LINE_W-1:0]     line_start,
    input logic [tlrs_pkg::LINE_W-1:0]     line_end,
    input logic                            has_line,
    input logic                            was_merged,
    input logic                            last_of_image
);

    // A stalled result word stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result word dropped while stalled");

    // A stalled result word keeps its line bounds.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(line_start) && $stable(line_end))
        else $error("result word changed while stalled");

    // A word without a line can only be the image terminator.
    a_bare_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_line |-> last_of_image)
        else $error("bare word without last_of_image");

    // A bare terminator carries zero bounds and no merge mark.
    a_bare_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_line |-> line_start == '0 && line_end == '0 && !was_merged)
        else $error("bare terminator carries line data");

    // A joined line is always emitted on its own, before the image terminator.
    a_merged_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && was_merged |-> has_line && !last_of_image)
        else $error("merged line flagged as last or without line");

endmodule

bind text_line_row_segmenter_unit tlrs_checker u_tlrs_checker (.*);
